// ----- hdl/lfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache package
// Shared constants, payload and control types for the LFU key-value cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int CAPACITY   = 16;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int OCC_BITS   = $clog2(CAPACITY + 1);
   localparam int CAP_BITS   = 5;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] lookup_key;
      logic signed [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic                load;
      logic                scan;
      logic [IDX_BITS-1:0] idx;
      logic                exec;
   } cmd_type;

   typedef struct packed {
      logic [OCC_BITS-1:0] occupancy;
   } status_type;

endpackage
`default_nettype wire

// ----- hdl/lfu_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences accept, slot scan and the single update state of each transaction.
// ----------------------------------------------------------------------------
module lfu_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output lfu_pkg::cmd_type     cmd
);
   import lfu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_BITS'(CAPACITY - 1)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign cmd.load = accept;
   assign cmd.scan = (state_ff == ST_SCAN);
   assign cmd.idx  = idx_ff;
   assign cmd.exec = (state_ff == ST_EXEC);

endmodule
`default_nettype wire

// ----- hdl/lfu_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache datapath
// Slot store, scan for hit, victim and free slot, and per-slot update lanes.
// ----------------------------------------------------------------------------
module lfu_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lfu_pkg::cmd_type   cmd,
   input  wire lfu_pkg::req_type   req_payload,
   input  wire logic               csr_write_en,
   input  wire logic [4:0]         csr_write_data,
   output logic                    rsp_strobe,
   output lfu_pkg::rsp_type        rsp_payload,
   output lfu_pkg::status_type     status
);
   import lfu_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [31:0]           key_ff   [CAPACITY];
   logic [31:0]           value_ff [CAPACITY];
   logic [COUNT_BITS-1:0] cnt_ff   [CAPACITY];
   logic [IDX_BITS-1:0]   rank_ff  [CAPACITY];

   logic [CAP_BITS-1:0]   cap_ff;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   req_type               req_ff;

   logic                  hit_found_ff, vic_found_ff, free_found_ff;
   logic [IDX_BITS-1:0]   hit_idx_ff, vic_idx_ff, free_idx_ff;
   logic [COUNT_BITS-1:0] vic_cnt_ff;
   logic [IDX_BITS-1:0]   vic_rank_ff;

   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;

   logic [CAP_BITS-1:0]   cap_eff;
   logic                  do_touch, do_put_new, need_evict, do_evict, do_insert;
   logic [IDX_BITS-1:0]   ins_idx;
   logic [IDX_BITS-1:0]   hit_rank;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_BITS'(CAPACITY);
      end else if (csr_write_en) begin
         cap_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
   end

   // scan one slot a cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_found_ff  <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (valid_ff[cmd.idx] && key_ff[cmd.idx] == req_ff.lookup_key && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= cmd.idx;
         end
         if (valid_ff[cmd.idx] && (!vic_found_ff || cnt_ff[cmd.idx] < vic_cnt_ff ||
             (cnt_ff[cmd.idx] == vic_cnt_ff && rank_ff[cmd.idx] > vic_rank_ff))) begin
            vic_found_ff <= 1'b1;
            vic_idx_ff   <= cmd.idx;
            vic_cnt_ff   <= cnt_ff[cmd.idx];
            vic_rank_ff  <= rank_ff[cmd.idx];
         end
         if (!valid_ff[cmd.idx] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= cmd.idx;
         end
      end
   end

   always_comb begin
      cap_eff    = (cap_ff > CAP_BITS'(CAPACITY)) ? CAP_BITS'(CAPACITY) : cap_ff;
      do_touch   = hit_found_ff && (req_ff.opcode == OP_GET || cap_eff != '0);
      do_put_new = (req_ff.opcode == OP_PUT) && (cap_eff != '0) && !hit_found_ff;
      need_evict = (CAP_BITS'(occ_ff) >= cap_eff) || !free_found_ff;
      do_evict   = do_put_new && need_evict && vic_found_ff;
      if (do_evict && !(free_found_ff && free_idx_ff < vic_idx_ff)) begin
         ins_idx = vic_idx_ff;
      end else begin
         ins_idx = free_idx_ff;
      end
      do_insert  = do_put_new && (do_evict || free_found_ff);
      hit_rank   = rank_ff[hit_idx_ff];
   end

   // per-slot update lanes
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int j = 0; j < CAPACITY; j++) begin
            if (do_touch) begin
               if (IDX_BITS'(j) == hit_idx_ff) begin
                  rank_ff[j] <= '0;
                  if (cnt_ff[j] != COUNT_MAX) begin
                     cnt_ff[j] <= cnt_ff[j] + 1'b1;
                  end
                  if (req_ff.opcode == OP_PUT) begin
                     value_ff[j] <= req_ff.new_value;
                  end
               end else if (valid_ff[j] && rank_ff[j] < hit_rank) begin
                  rank_ff[j] <= rank_ff[j] + 1'b1;
               end
            end else if (do_insert) begin
               if (IDX_BITS'(j) == ins_idx) begin
                  key_ff[j]   <= req_ff.lookup_key;
                  value_ff[j] <= req_ff.new_value;
                  cnt_ff[j]   <= COUNT_BITS'(1);
                  rank_ff[j]  <= '0;
               end else if (valid_ff[j] && !(do_evict && IDX_BITS'(j) == vic_idx_ff)) begin
                  // close the evicted slot's gap, then age for the newcomer
                  if (do_evict && rank_ff[j] > vic_rank_ff) begin
                     rank_ff[j] <= rank_ff[j];
                  end else begin
                     rank_ff[j] <= rank_ff[j] + 1'b1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      if (cmd.exec) begin
         if (do_evict) begin
            valid_in[vic_idx_ff] = 1'b0;
         end
         if (do_insert) begin
            valid_in[ins_idx] = 1'b1;
         end
         occ_in = occ_ff - OCC_BITS'(do_evict) + OCC_BITS'(do_insert);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff.found <= hit_found_ff;
         if (req_ff.opcode == OP_GET && hit_found_ff) begin
            rsp_ff.read_value <= value_ff[hit_idx_ff];
         end else begin
            rsp_ff.read_value <= '0;
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_payload      = rsp_ff;
   assign status.occupancy = occ_ff;

endmodule
`default_nettype wire

// ----- hdl/lfu_key_value_cache_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU key-value cache
// Sixteen-slot cache with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The controller
// then scans the sixteen slots one per cycle for a key match, the eviction
// victim and the lowest free slot, then updates every slot in parallel;
// busy stays high until that update is done, so no new transaction is
// taken before then. The result appears on rsp_payload with rsp_strobe
// for one cycle, in the cycle in which busy falls. The receiver cannot
// stall, so it must take every result as it comes. csr_write_data sets the
// capacity; write it only while busy is low.
module lfu_key_value_cache_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lfu_pkg::req_type req_payload,
   output logic                  rsp_strobe,
   output lfu_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_write_en,
   input  wire logic [4:0]       csr_write_data
);
   import lfu_pkg::*;

   cmd_type    cmd;
   status_type status;

   lfu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lfu_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_payload    (rsp_payload),
      .status         (status)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result while busy");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $fell(busy)) else $error("result without a transaction");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      status.occupancy <= OCC_BITS'(CAPACITY)) else $error("occupancy overflow");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU key-value cache testbench
// Drives get and put transactions through the start/busy handshake, predicts
// every response with a behavioural cache model and compares each strobed
// response field by field. Capacity is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
   import lfu_pkg::*;

   localparam int  CACHE_SLOTS = 16;
   localparam int  LIMIT       = 400000;
   localparam logic [15:0] COUNT_TOP = 16'hFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_payload = '0;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        csr_write_en = 1'b0;
   logic [4:0]  csr_write_data = '0;

   lfu_key_value_cache_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // cache model state
   logic        m_valid [CACHE_SLOTS];
   logic [31:0] m_key   [CACHE_SLOTS];
   logic [31:0] m_value [CACHE_SLOTS];
   logic [15:0] m_count [CACHE_SLOTS];
   logic [4:0]  m_rank  [CACHE_SLOTS];
   int          m_occupancy;
   logic [4:0]  m_capacity;

   req_type     pending_ops[$];
   rsp_type     expected_rsps[$];
   int          send_idle_pct = 8;
   int          errors = 0;
   int          cycles = 0;

   function automatic void touch_slot(int s);
      for (int j = 0; j < CACHE_SLOTS; j++)
         if (m_valid[j] && j != s && m_rank[j] < m_rank[s]) m_rank[j]++;
      m_rank[s] = '0;
      if (m_count[s] != COUNT_TOP) m_count[s]++;
   endfunction

   function automatic int free_slot();
      for (int j = 0; j < CACHE_SLOTS; j++)
         if (!m_valid[j]) return j;
      return -1;
   endfunction

   function automatic void evict_victim();
      int v;
      v = -1;
      for (int j = 0; j < CACHE_SLOTS; j++) begin
         if (!m_valid[j]) continue;
         if (v < 0 || m_count[j] < m_count[v] ||
             (m_count[j] == m_count[v] && m_rank[j] > m_rank[v])) v = j;
      end
      if (v < 0) return;
      for (int j = 0; j < CACHE_SLOTS; j++)
         if (m_valid[j] && j != v && m_rank[j] > m_rank[v]) m_rank[j]--;
      m_valid[v] = 1'b0;
      if (m_occupancy > 0) m_occupancy--;
   endfunction

   function automatic rsp_type cache_access(req_type op);
      rsp_type r;
      int hit, s, cap;
      hit = -1;
      cap = (m_capacity > CACHE_SLOTS) ? CACHE_SLOTS : int'(m_capacity);
      for (int j = 0; j < CACHE_SLOTS; j++)
         if (hit < 0 && m_valid[j] && m_key[j] == op.lookup_key) hit = j;
      r.found = (hit >= 0);
      r.read_value = '0;
      if (op.opcode == OP_GET) begin
         if (hit >= 0) begin
            r.read_value = m_value[hit];
            touch_slot(hit);
         end
      end else if (cap != 0) begin
         if (hit >= 0) begin
            m_value[hit] = op.new_value;
            touch_slot(hit);
         end else begin
            if (m_occupancy >= cap || free_slot() < 0) evict_victim();
            s = free_slot();
            if (s >= 0) begin
               for (int j = 0; j < CACHE_SLOTS; j++)
                  if (m_valid[j]) m_rank[j]++;
               m_valid[s] = 1'b1;
               m_key[s]   = op.lookup_key;
               m_value[s] = op.new_value;
               m_count[s] = 16'd1;
               m_rank[s]  = '0;
               m_occupancy++;
            end
         end
      end
      return r;
   endfunction

   // driver: predict at acceptance so the model sees transactions in order
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         expected_rsps.push_back(cache_access(req_payload));
         if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_ops.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         start       <= 1'b1;
         req_payload <= pending_ops.pop_front();
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response found=%0b value=%0d", $time,
                     rsp_payload.found, rsp_payload.read_value);
            errors = errors + 1;
         end else begin
            if (rsp_payload.found !== expected_rsps[0].found) begin
               $display("%0t: found expected %0b actual %0b", $time,
                        expected_rsps[0].found, rsp_payload.found);
               errors = errors + 1;
            end
            if (rsp_payload.read_value !== expected_rsps[0].read_value) begin
               $display("%0t: read_value expected %0d actual %0d", $time,
                        expected_rsps[0].read_value, rsp_payload.read_value);
               errors = errors + 1;
            end
            void'(expected_rsps.pop_front());
         end
      end
      if (cycles > LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   function automatic req_type make_op(logic opc, logic [31:0] k, logic [31:0] v);
      req_type t;
      t.opcode = opc;
      t.lookup_key = k;
      t.new_value = v;
      return t;
   endfunction

   // small key pool forces hits and evictions; now and then a wide random key
   function automatic logic [31:0] pick_key(int pool);
      if ($urandom_range(9) == 0) return $urandom();
      return 32'h8000_0000 ^ $urandom_range(pool - 1);
   endfunction

   task automatic wait_idle();
      while (pending_ops.size() > 0 || start || busy || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic set_capacity(logic [4:0] c);
      csr_write_en   <= 1'b1;
      csr_write_data <= c;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      m_capacity = c;
      @(posedge clock);
   endtask

   task automatic run_random(int n, int pool, int put_pct);
      for (int i = 0; i < n; i++)
         pending_ops.push_back(make_op($urandom_range(99) < put_pct, pick_key(pool),
                                       $urandom()));
      wait_idle();
   endtask

   initial begin
      logic [4:0] caps [6];
      for (int j = 0; j < CACHE_SLOTS; j++) m_valid[j] = 1'b0;
      m_occupancy = 0;
      m_capacity  = 5'd16;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, hits, updates, misses
      pending_ops.push_back(make_op(OP_GET, 32'h0, 32'h0));
      pending_ops.push_back(make_op(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
      pending_ops.push_back(make_op(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
      pending_ops.push_back(make_op(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(OP_GET, 32'h8000_0000, 32'h1234_5678));
      pending_ops.push_back(make_op(OP_GET, 32'h7FFF_FFFF, 32'h0));
      pending_ops.push_back(make_op(OP_PUT, 32'h7FFF_FFFF, 32'h0));
      pending_ops.push_back(make_op(OP_GET, 32'h7FFF_FFFF, 32'h0));
      pending_ops.push_back(make_op(OP_GET, 32'h0000_0001, 32'h0));
      wait_idle();
      // shrink below occupancy, then insert to force a single eviction
      set_capacity(5'd2);
      pending_ops.push_back(make_op(OP_PUT, 32'h0000_0005, 32'h5555_AAAA));
      pending_ops.push_back(make_op(OP_GET, 32'hFFFF_FFFF, 32'h0));
      pending_ops.push_back(make_op(OP_GET, 32'h8000_0000, 32'h0));
      pending_ops.push_back(make_op(OP_GET, 32'h0000_0005, 32'h0));
      wait_idle();
      // capacity zero: puts ignored, gets still hit
      set_capacity(5'd0);
      pending_ops.push_back(make_op(OP_PUT, 32'h0000_0005, 32'h1));
      pending_ops.push_back(make_op(OP_PUT, 32'h0000_0009, 32'h2));
      pending_ops.push_back(make_op(OP_GET, 32'h0000_0005, 32'h0));
      pending_ops.push_back(make_op(OP_GET, 32'h0000_0009, 32'h0));
      wait_idle();
      // capacity above the slot count clamps
      set_capacity(5'd31);
      for (int i = 0; i < 20; i++)
         pending_ops.push_back(make_op(OP_PUT, i, ~i));
      wait_idle();

      caps = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd9, 5'd31};
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 8 : (p == 1) ? 78 : 0;
         for (int c = 0; c < 6; c++) begin
            set_capacity(caps[c]);
            run_random(55, (c == 1) ? 4 : 24, 55);
         end
      end
      // saturation would need 65534 touches; hammer one key briefly instead
      set_capacity(5'd16);
      pending_ops.push_back(make_op(OP_PUT, 32'h0000_0042, 32'h42));
      for (int i = 0; i < 30; i++)
         pending_ops.push_back(make_op(OP_GET, 32'h0000_0042, 32'h0));
      wait_idle();

      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
